>>> rtl/core/mrtb_pkg.sv
// ----------------------------------------------------------------------------
// mrtb_pkg
// Shared codes, constants, types and helpers of the tick and buzzer unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrtb_pkg;

   // request kinds
   localparam logic [1:0] KIND_TICK    = 2'd0;
   localparam logic [1:0] KIND_START   = 2'd1;
   localparam logic [1:0] KIND_CLR_KEY = 2'd2;
   localparam logic [1:0] KIND_CLR_UV  = 2'd3;

   localparam int unsigned TPM_W = 5;
   localparam logic [TPM_W-1:0] TPM_MIN   = 5'd1;
   localparam logic [TPM_W-1:0] TPM_MAX   = 5'd20;
   localparam logic [TPM_W-1:0] TPM_RESET = 5'd10;

   localparam logic [31:0] MS_WRAP      = 32'hFFFF_FFFF;
   localparam logic [11:0] BUZZ_TAIL_MS = 12'd200;

   localparam int unsigned TAIL_W = 12;

   // one buzzer command per accepted request
   typedef struct packed {
      logic              tick;
      logic              start;
      logic [15:0]       duration;
      logic [7:0]        half_period;
      logic [TAIL_W-1:0] tail_ticks;
   } buzz_cmd_type;

   function automatic logic [TPM_W-1:0] clamp_tpm(input logic [TPM_W-1:0] raw);
      logic [TPM_W-1:0] val;
      val = raw;
      if (raw < TPM_MIN) begin
         val = TPM_MIN;
      end else if (raw > TPM_MAX) begin
         val = TPM_MAX;
      end
      return val;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/mrtb_buzzer.sv
// ----------------------------------------------------------------------------
// mrtb_buzzer
// Two-pin buzzer driver: N toggles each half period, P drops near the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrtb_buzzer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mrtb_pkg::buzz_cmd_type cmd,
   output logic                      pin_p_in,
   output logic                      pin_n_in
);
   import mrtb_pkg::*;

   logic [15:0] left_ff, left_in;
   logic [7:0]  half_left_ff, half_left_in;
   logic [7:0]  reload_ff, reload_in;
   logic        pin_p_ff;
   logic        pin_n_ff;
   logic [7:0]  half_dec;
   logic [15:0] left_dec;

   assign half_dec = half_left_ff - 8'd1;
   assign left_dec = left_ff - 16'd1;

   always_comb begin
      left_in      = left_ff;
      half_left_in = half_left_ff;
      reload_in    = reload_ff;
      pin_p_in     = pin_p_ff;
      pin_n_in     = pin_n_ff;
      if (cmd.start) begin
         if (cmd.duration == 16'd0) begin
            left_in      = '0;
            half_left_in = '0;
            reload_in    = '0;
            pin_p_in     = 1'b0;
            pin_n_in     = 1'b0;
         end else begin
            left_in      = cmd.duration;
            half_left_in = cmd.half_period;
            reload_in    = cmd.half_period;
            pin_p_in     = 1'b1;
            pin_n_in     = 1'b0;
         end
      end else if (cmd.tick && (left_ff != 16'd0)) begin
         half_left_in = half_dec;
         if (half_dec == 8'd0) begin
            pin_n_in     = ~pin_n_ff;
            half_left_in = reload_ff;
         end
         left_in = left_dec;
         if (left_dec == 16'd0) begin
            half_left_in = '0;
            pin_p_in     = 1'b0;
            pin_n_in     = 1'b0;
         end else if (left_dec == 16'(cmd.tail_ticks)) begin
            // drop P for the closing tail
            pin_p_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         half_left_ff <= '0;
         reload_ff    <= '0;
         pin_p_ff     <= 1'b0;
         pin_n_ff     <= 1'b0;
      end else begin
         left_ff      <= left_in;
         half_left_ff <= half_left_in;
         reload_ff    <= reload_in;
         pin_p_ff     <= pin_p_in;
         pin_n_ff     <= pin_n_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/multi_rate_tick_and_buzzer_unit.sv
// ----------------------------------------------------------------------------
// multi_rate_tick_and_buzzer_unit
// Tick dividers, system time, UV and key counters, and buzzer driver.
// ----------------------------------------------------------------------------
// Path: a request is captured in the input register, then one pass of counter
//   logic loads the response register once that register can advance, that
//   is, when it is empty or not held by rsp_stall.
// Throughput: one request per cycle while rsp_stall is low; the response
//   and input registers let a new request in while a response is held.
// Reset: synchronous, clears all counters and pins, loads ticks_per_ms = 10
//   and the dividers with their scaled reload values.
`timescale 1ns / 1ps
`default_nettype none

module multi_rate_tick_and_buzzer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [4:0]  csr_data,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic        req_uv_on,
   input  wire logic        req_uv_check_enable,
   input  wire logic        req_key_counting,
   input  wire logic [15:0] req_buzz_duration,
   input  wire logic [7:0]  req_buzz_half_period,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_pulse_1ms,
   output logic             rsp_pulse_2ms,
   output logic             rsp_pulse_10ms,
   output logic             rsp_pulse_100ms,
   output logic             rsp_pulse_1s,
   output logic             rsp_uv_check_pulse,
   output logic [31:0]      rsp_ms_time,
   output logic [31:0]      rsp_s_time,
   output logic [15:0]      rsp_uv_interval,
   output logic [15:0]      rsp_key_count,
   output logic             rsp_buzzer_p,
   output logic             rsp_buzzer_n
);
   import mrtb_pkg::*;

   // ---------------- configuration ----------------
   logic [TPM_W-1:0] tpm_ff;
   logic [TPM_W-1:0] tpm_eff;

   assign csr_ready = 1'b1;
   assign tpm_eff   = clamp_tpm(tpm_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tpm_ff <= TPM_RESET;
      end else if (csr_valid && csr_ready) begin
         tpm_ff <= csr_data;
      end
   end

   // ---------------- handshake ----------------
   logic        in_valid_ff, in_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_adv;
   logic        step;
   logic        in_load;

   logic [1:0]  kind_ff;
   logic        uv_on_ff;
   logic        uv_chk_ff;
   logic        key_cnt_ff;
   logic [15:0] dur_ff;
   logic [7:0]  half_ff;

   assign out_adv      = ~rsp_valid_ff | ~rsp_stall;
   assign step         = in_valid_ff & out_adv;
   assign req_stall    = in_valid_ff & ~out_adv;
   assign in_load      = req_valid & ~req_stall;
   assign in_valid_in  = in_load | (in_valid_ff & ~out_adv);
   assign rsp_valid_in = step | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         kind_ff    <= req_kind;
         uv_on_ff   <= req_uv_on;
         uv_chk_ff  <= req_uv_check_enable;
         key_cnt_ff <= req_key_counting;
         dur_ff     <= req_buzz_duration;
         half_ff    <= req_buzz_half_period;
      end
   end

   // ---------------- kind decode ----------------
   logic is_tick, is_start, is_clr_key, is_clr_uv;

   always_comb begin
      is_tick    = 1'b0;
      is_start   = 1'b0;
      is_clr_key = 1'b0;
      is_clr_uv  = 1'b0;
      unique case (kind_ff)
         KIND_TICK:    is_tick    = step;
         KIND_START:   is_start   = step;
         KIND_CLR_KEY: is_clr_key = step;
         KIND_CLR_UV:  is_clr_uv  = step;
         default:      is_tick    = 1'b0;
      endcase
   end

   // ---------------- dividers ----------------
   logic [4:0]  rl_1ms;
   logic [5:0]  rl_2ms;
   logic [7:0]  rl_10ms;
   logic [10:0] rl_100ms;
   logic [14:0] rl_1s;

   assign rl_1ms   = tpm_eff;
   assign rl_2ms   = {tpm_eff, 1'b0};
   assign rl_10ms  = 8'(tpm_eff) * 8'd10;
   assign rl_100ms = 11'(tpm_eff) * 11'd100;
   assign rl_1s    = 15'(tpm_eff) * 15'd1000;

   logic [4:0]  div_1ms_ff,   div_1ms_in,   dec_1ms;
   logic [5:0]  div_2ms_ff,   div_2ms_in,   dec_2ms;
   logic [7:0]  div_10ms_ff,  div_10ms_in,  dec_10ms;
   logic [10:0] div_100ms_ff, div_100ms_in, dec_100ms;
   logic [14:0] div_1s_ff,    div_1s_in,    dec_1s;
   logic        p1, p2, p10, p100, p1s, pchk;

   assign dec_1ms   = div_1ms_ff - 5'd1;
   assign dec_2ms   = div_2ms_ff - 6'd1;
   assign dec_10ms  = div_10ms_ff - 8'd1;
   assign dec_100ms = div_100ms_ff - 11'd1;
   assign dec_1s    = div_1s_ff - 15'd1;

   assign p1   = is_tick & (dec_1ms == '0);
   assign p2   = is_tick & (dec_2ms == '0);
   assign p10  = is_tick & (dec_10ms == '0);
   assign p100 = is_tick & (dec_100ms == '0);
   assign p1s  = is_tick & (dec_1s == '0);
   assign pchk = p1s & uv_on_ff & uv_chk_ff;

   // reload on expiry, otherwise count down; hold on non-tick requests
   assign div_1ms_in   = !is_tick ? div_1ms_ff   : (p1   ? rl_1ms   : dec_1ms);
   assign div_2ms_in   = !is_tick ? div_2ms_ff   : (p2   ? rl_2ms   : dec_2ms);
   assign div_10ms_in  = !is_tick ? div_10ms_ff  : (p10  ? rl_10ms  : dec_10ms);
   assign div_100ms_in = !is_tick ? div_100ms_ff : (p100 ? rl_100ms : dec_100ms);
   assign div_1s_in    = !is_tick ? div_1s_ff    : (p1s  ? rl_1s    : dec_1s);

   always_ff @(posedge clock) begin
      if (reset) begin
         div_1ms_ff   <= TPM_RESET;
         div_2ms_ff   <= 6'(TPM_RESET) * 6'd2;
         div_10ms_ff  <= 8'(TPM_RESET) * 8'd10;
         div_100ms_ff <= 11'(TPM_RESET) * 11'd100;
         div_1s_ff    <= 15'(TPM_RESET) * 15'd1000;
      end else begin
         div_1ms_ff   <= div_1ms_in;
         div_2ms_ff   <= div_2ms_in;
         div_10ms_ff  <= div_10ms_in;
         div_100ms_ff <= div_100ms_in;
         div_1s_ff    <= div_1s_in;
      end
   end

   // ---------------- time and event counters ----------------
   logic [31:0] millis_ff, millis_in, millis_inc;
   logic [31:0] seconds_ff, seconds_in;
   logic [15:0] uv_sec_ff, uv_sec_in;
   logic [15:0] key_ff, key_in;

   assign millis_inc = millis_ff + 32'd1;

   always_comb begin
      millis_in  = millis_ff;
      seconds_in = seconds_ff;
      uv_sec_in  = uv_sec_ff;
      key_in     = key_ff;
      if (p1) begin
         // skip all ones, wrap straight to zero
         millis_in = (millis_inc == MS_WRAP) ? 32'd0 : millis_inc;
      end
      if (p1s) begin
         seconds_in = seconds_ff + 32'd1;
         if (uv_on_ff) begin
            uv_sec_in = uv_sec_ff + 16'd1;
         end
      end
      if (is_tick && key_cnt_ff) begin
         key_in = key_ff + 16'd1;
      end
      if (is_clr_key) begin
         key_in = '0;
      end
      if (is_clr_uv) begin
         uv_sec_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         millis_ff  <= '0;
         seconds_ff <= '0;
         uv_sec_ff  <= '0;
         key_ff     <= '0;
      end else begin
         millis_ff  <= millis_in;
         seconds_ff <= seconds_in;
         uv_sec_ff  <= uv_sec_in;
         key_ff     <= key_in;
      end
   end

   // ---------------- buzzer ----------------
   buzz_cmd_type buzz_cmd;
   logic         pin_p_in;
   logic         pin_n_in;

   assign buzz_cmd.tick        = is_tick;
   assign buzz_cmd.start       = is_start;
   assign buzz_cmd.duration    = dur_ff;
   assign buzz_cmd.half_period = half_ff;
   assign buzz_cmd.tail_ticks  = TAIL_W'(tpm_eff) * BUZZ_TAIL_MS;

   mrtb_buzzer u_buzzer (
      .clock    (clock),
      .reset    (reset),
      .cmd      (buzz_cmd),
      .pin_p_in (pin_p_in),
      .pin_n_in (pin_n_in)
   );

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_pulse_1ms      <= p1;
         rsp_pulse_2ms      <= p2;
         rsp_pulse_10ms     <= p10;
         rsp_pulse_100ms    <= p100;
         rsp_pulse_1s       <= p1s;
         rsp_uv_check_pulse <= pchk;
         rsp_ms_time        <= millis_in;
         rsp_s_time         <= seconds_in;
         rsp_uv_interval    <= uv_sec_in;
         rsp_key_count      <= key_in;
         rsp_buzzer_p       <= pin_p_in;
         rsp_buzzer_n       <= pin_n_in;
      end
   end

   // ---------------- assertions ----------------
   a_chk_needs_second: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_uv_check_pulse |-> rsp_pulse_1s)
      else $error("check pulse without second pulse");

   a_ms_skips_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ms_time != MS_WRAP)
      else $error("millisecond time reached all ones");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_1ms_ff != '0 && div_2ms_ff != '0 && div_10ms_ff != '0
      && div_100ms_ff != '0 && div_1s_ff != '0)
      else $error("divider reached zero");

   a_held_request: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_adv |=> in_valid_ff && $stable(kind_ff))
      else $error("held request lost");

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for multi_rate_tick_and_buzzer_unit. Sends tick,
// buzzer-start and clear requests under changing flow control and tick
// scales. A local model tracks the dividers, time counters and buzzer pins,
// and every response is compared field by field with the next prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import mrtb_pkg::*;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned LONG_TICKS  = 100;
   localparam int unsigned PHASE_ITEMS = 120;
   localparam int unsigned TAIL_MS     = 200;
   localparam logic [31:0] MS_LAST     = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  kind;
      logic        uv_on;
      logic        uv_check_enable;
      logic        key_counting;
      logic [15:0] buzz_duration;
      logic [7:0]  buzz_half_period;
   } timer_req_type;

   typedef struct packed {
      logic        pulse_1ms;
      logic        pulse_2ms;
      logic        pulse_10ms;
      logic        pulse_100ms;
      logic        pulse_1s;
      logic        uv_check_pulse;
      logic [31:0] ms_time;
      logic [31:0] s_time;
      logic [15:0] uv_interval;
      logic [15:0] key_count;
      logic        buzzer_p;
      logic        buzzer_n;
   } timer_reading_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = KIND_TICK;
   logic        req_uv_on = 1'b0;
   logic        req_uv_check_enable = 1'b0;
   logic        req_key_counting = 1'b0;
   logic [15:0] req_buzz_duration = '0;
   logic [7:0]  req_buzz_half_period = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_pulse_1ms;
   logic        rsp_pulse_2ms;
   logic        rsp_pulse_10ms;
   logic        rsp_pulse_100ms;
   logic        rsp_pulse_1s;
   logic        rsp_uv_check_pulse;
   logic [31:0] rsp_ms_time;
   logic [31:0] rsp_s_time;
   logic [15:0] rsp_uv_interval;
   logic [15:0] rsp_key_count;
   logic        rsp_buzzer_p;
   logic        rsp_buzzer_n;

   multi_rate_tick_and_buzzer_unit dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_kind             (req_kind),
      .req_uv_on            (req_uv_on),
      .req_uv_check_enable  (req_uv_check_enable),
      .req_key_counting     (req_key_counting),
      .req_buzz_duration    (req_buzz_duration),
      .req_buzz_half_period (req_buzz_half_period),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pulse_1ms        (rsp_pulse_1ms),
      .rsp_pulse_2ms        (rsp_pulse_2ms),
      .rsp_pulse_10ms       (rsp_pulse_10ms),
      .rsp_pulse_100ms      (rsp_pulse_100ms),
      .rsp_pulse_1s         (rsp_pulse_1s),
      .rsp_uv_check_pulse   (rsp_uv_check_pulse),
      .rsp_ms_time          (rsp_ms_time),
      .rsp_s_time           (rsp_s_time),
      .rsp_uv_interval      (rsp_uv_interval),
      .rsp_key_count        (rsp_key_count),
      .rsp_buzzer_p         (rsp_buzzer_p),
      .rsp_buzzer_n         (rsp_buzzer_n)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // model state, starting from the reset values
   logic [4:0]  tpm_reg        = TPM_RESET;
   logic [14:0] div1           = 15'(TPM_RESET);
   logic [14:0] div2           = 15'(TPM_RESET) * 15'd2;
   logic [14:0] div10          = 15'(TPM_RESET) * 15'd10;
   logic [14:0] div100         = 15'(TPM_RESET) * 15'd100;
   logic [14:0] div1k          = 15'(TPM_RESET) * 15'd1000;
   logic [31:0] ms_acc         = '0;
   logic [31:0] sec_acc        = '0;
   logic [15:0] uv_acc         = '0;
   logic [15:0] key_acc        = '0;
   logic [15:0] buzz_remaining = '0;
   logic [7:0]  half_remaining = '0;
   logic [7:0]  half_reload    = '0;
   logic        pin_p_lvl      = 1'b0;
   logic        pin_n_lvl      = 1'b0;

   timer_reading_type expected_readings[$];

   int unsigned errors = 0;
   int unsigned requests_sent = 0;
   int unsigned readings_checked = 0;
   int unsigned second_pulses = 0;
   int unsigned key_wraps = 0;
   int unsigned tail_drops = 0;
   int unsigned quiet_cycles = 0;
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_left = 0;

   // {expired, next value} of one down-counting divider
   function automatic logic [15:0] div_next(input logic [14:0] d, input logic [14:0] reload);
      logic [14:0] nd;
      nd = d - 15'd1;
      if (nd == 15'd0) begin
         return {1'b1, reload};
      end
      return {1'b0, nd};
   endfunction

   function automatic timer_reading_type advance_timers(input timer_req_type r);
      timer_reading_type o;
      logic [15:0] nx;
      logic [14:0] t;
      o = '0;
      if (tpm_reg < TPM_MIN) begin
         t = 15'(TPM_MIN);
      end else if (tpm_reg > TPM_MAX) begin
         t = 15'(TPM_MAX);
      end else begin
         t = 15'(tpm_reg);
      end
      case (r.kind)
         KIND_TICK: begin
            nx = div_next(div1, t);
            o.pulse_1ms = nx[15];
            div1 = nx[14:0];
            nx = div_next(div2, t * 15'd2);
            o.pulse_2ms = nx[15];
            div2 = nx[14:0];
            nx = div_next(div10, t * 15'd10);
            o.pulse_10ms = nx[15];
            div10 = nx[14:0];
            nx = div_next(div100, t * 15'd100);
            o.pulse_100ms = nx[15];
            div100 = nx[14:0];
            nx = div_next(div1k, t * 15'd1000);
            o.pulse_1s = nx[15];
            div1k = nx[14:0];
            if (o.pulse_1ms) begin
               // skip the all-ones value
               ms_acc = ms_acc + 32'd1;
               if (ms_acc == MS_LAST) begin
                  ms_acc = '0;
               end
            end
            if (o.pulse_1s) begin
               second_pulses++;
               if (r.uv_on) begin
                  uv_acc = uv_acc + 16'd1;
                  o.uv_check_pulse = r.uv_check_enable;
               end
               sec_acc = sec_acc + 32'd1;
            end
            if (r.key_counting) begin
               key_acc = key_acc + 16'd1;
               if (key_acc == 16'd0) begin
                  key_wraps++;
               end
            end
            if (buzz_remaining != 16'd0) begin
               half_remaining = half_remaining - 8'd1;
               if (half_remaining == 8'd0) begin
                  pin_n_lvl = ~pin_n_lvl;
                  half_remaining = half_reload;
               end
               buzz_remaining = buzz_remaining - 16'd1;
               if (buzz_remaining == 16'd0) begin
                  half_remaining = '0;
                  pin_p_lvl = 1'b0;
                  pin_n_lvl = 1'b0;
               end else if (buzz_remaining == 16'(TAIL_MS * t)) begin
                  pin_p_lvl = 1'b0;
                  tail_drops++;
               end
            end
         end
         KIND_START: begin
            if (r.buzz_duration == 16'd0) begin
               buzz_remaining = '0;
               half_remaining = '0;
               half_reload = '0;
               pin_p_lvl = 1'b0;
            end else begin
               buzz_remaining = r.buzz_duration;
               half_remaining = r.buzz_half_period;
               half_reload = r.buzz_half_period;
               pin_p_lvl = 1'b1;
            end
            pin_n_lvl = 1'b0;
         end
         KIND_CLR_KEY: begin
            key_acc = '0;
         end
         default: begin
            uv_acc = '0;
         end
      endcase
      o.ms_time = ms_acc;
      o.s_time = sec_acc;
      o.uv_interval = uv_acc;
      o.key_count = key_acc;
      o.buzzer_p = pin_p_lvl;
      o.buzzer_n = pin_n_lvl;
      return o;
   endfunction

   function automatic timer_req_type make_req(input logic [1:0] kind, input logic uv,
                                              input logic chk, input logic key,
                                              input logic [15:0] dur, input logic [7:0] half);
      timer_req_type r;
      r.kind = kind;
      r.uv_on = uv;
      r.uv_check_enable = chk;
      r.key_counting = key;
      r.buzz_duration = dur;
      r.buzz_half_period = half;
      return r;
   endfunction

   function automatic timer_req_type rand_request(input logic [1:0] kind);
      return make_req(kind, 1'($urandom), 1'($urandom), 1'($urandom),
                      16'($urandom), 8'($urandom));
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   task automatic send_request(input timer_req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_kind <= r.kind;
      req_uv_on <= r.uv_on;
      req_uv_check_enable <= r.uv_check_enable;
      req_key_counting <= r.key_counting;
      req_buzz_duration <= r.buzz_duration;
      req_buzz_half_period <= r.buzz_half_period;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_readings.push_back(advance_timers(r));
      requests_sent++;
   endtask

   // hold the sender until every response is back
   task automatic drain_requests();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_readings.size() != 0);
   endtask

   task automatic write_scale(input logic [4:0] value);
      drain_requests();
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tpm_reg = value;
   endtask

   task automatic test_directed();
      send_request(make_req(KIND_TICK, 1'b0, 1'b0, 1'b0, 16'hFFFF, 8'hFF));
      send_request(make_req(KIND_TICK, 1'b1, 1'b1, 1'b1, 16'h0000, 8'h00));
      send_request(make_req(KIND_CLR_KEY, 1'b1, 1'b1, 1'b1, 16'h0000, 8'h00));
      send_request(make_req(KIND_CLR_UV, 1'b0, 1'b0, 1'b0, 16'hFFFF, 8'hFF));
      // stop while idle, then the longest buzz with a wrapping half period
      send_request(make_req(KIND_START, 1'b0, 1'b0, 1'b0, 16'd0, 8'd255));
      send_request(make_req(KIND_START, 1'b1, 1'b1, 1'b1, 16'hFFFF, 8'd0));
      send_request(make_req(KIND_TICK, 1'b0, 1'b0, 1'b0, 16'd0, 8'd0));
      // restart mid-buzz: short run, N toggles every tick, P held to the end
      send_request(make_req(KIND_START, 1'b0, 1'b0, 1'b0, 16'd4, 8'd1));
      repeat (4) send_request(make_req(KIND_TICK, 1'b0, 1'b0, 1'b1, 16'd0, 8'd0));
      send_request(make_req(KIND_START, 1'b0, 1'b0, 1'b0, 16'd3, 8'd255));
      repeat (3) send_request(make_req(KIND_TICK, 1'b1, 1'b0, 1'b0, 16'd0, 8'd0));
      send_request(make_req(KIND_START, 1'b0, 1'b0, 1'b0, 16'd2, 8'd0));
      // zero duration stops a running buzzer
      send_request(make_req(KIND_START, 1'b0, 1'b0, 1'b0, 16'd0, 8'd0));
      send_request(make_req(KIND_TICK, 1'b0, 1'b0, 1'b1, 16'd0, 8'd0));
   endtask

   // fastest scale, mostly ticks with the odd buzzer start and UV clear
   task automatic test_long_count();
      timer_req_type r;
      int unsigned n;
      int unsigned dice;
      idle_pct = 0;
      stall_pct = 0;
      write_scale(TPM_MIN);
      for (n = 0; n < LONG_TICKS; n++) begin
         dice = $urandom_range(999);
         r = rand_request(KIND_TICK);
         r.key_counting = 1'b1;
         r.uv_on = ($urandom_range(99) < 70);
         if (dice < 30) begin
            r.kind = KIND_START;
            if (dice != 0) begin
               r.buzz_duration = 16'($urandom_range(TAIL_MS + 1, 260));
            end
         end else if (dice < 40) begin
            r.kind = KIND_CLR_UV;
         end
         send_request(r);
      end
   endtask

   task automatic test_random_phase(input int unsigned idle, input int unsigned stall,
                                    input logic [4:0] scale);
      timer_req_type r;
      int unsigned sent;
      int unsigned dice;
      int unsigned ticks;
      idle_pct = idle;
      stall_pct = stall;
      write_scale(scale);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         dice = $urandom_range(99);
         if (dice < 15) begin
            send_request(rand_request(2'($urandom_range(3))));
            sent++;
         end else if (dice < 25) begin
            send_request(rand_request(($urandom_range(1)) ? KIND_CLR_KEY : KIND_CLR_UV));
            sent++;
         end else begin
            if (dice < 70) begin
               r = rand_request(KIND_START);
               r.buzz_duration = 16'($urandom_range(1, 90));
               r.buzz_half_period = 8'($urandom_range(0, 9));
               send_request(r);
               sent++;
            end
            ticks = $urandom_range(4, 60);
            repeat (ticks) send_request(rand_request(KIND_TICK));
            sent += ticks;
         end
      end
   endtask

   // long receiver hold-off while the sender keeps offering requests, then a full drain
   task automatic test_backpressure();
      idle_pct = 0;
      stall_pct = 0;
      write_scale(5'd21);
      hold_left = 150;
      repeat (40) send_request(rand_request(KIND_TICK));
      drain_requests();
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin : check_readings
      timer_reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readings.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            want = expected_readings.pop_front();
            check_field("pulse_1ms", want.pulse_1ms, rsp_pulse_1ms);
            check_field("pulse_2ms", want.pulse_2ms, rsp_pulse_2ms);
            check_field("pulse_10ms", want.pulse_10ms, rsp_pulse_10ms);
            check_field("pulse_100ms", want.pulse_100ms, rsp_pulse_100ms);
            check_field("pulse_1s", want.pulse_1s, rsp_pulse_1s);
            check_field("uv_check_pulse", want.uv_check_pulse, rsp_uv_check_pulse);
            check_field("ms_time", want.ms_time, rsp_ms_time);
            check_field("s_time", want.s_time, rsp_s_time);
            check_field("uv_interval", want.uv_interval, rsp_uv_interval);
            check_field("key_count", want.key_count, rsp_key_count);
            check_field("buzzer_p", want.buzzer_p, rsp_buzzer_p);
            check_field("buzzer_n", want.buzzer_n, rsp_buzzer_n);
            readings_checked++;
         end
      end
   end

   // end the run if no handshake completes for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_long_count();
      test_random_phase(0, 0, 5'd0);
      test_random_phase(77, 0, 5'd31);
      test_random_phase(0, 77, TPM_MAX);
      test_random_phase(11, 11, 5'($urandom_range(2, 9)));
      test_backpressure();
      drain_requests();
      repeat (8) @(posedge clock);
      $display("tb: %0d requests sent, %0d responses checked, scales 0 to 31",
               requests_sent, readings_checked);
      $display("tb: %0d second pulses, %0d key count wraps, %0d buzzer tail drops",
               second_pulses, key_wraps, tail_drops);
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
